### rtl/timed_led_event_table_defines.svh
// Assertion macros for the timed LED event table.
// Depends on nothing; the including module must provide clk and rst.
`ifndef TIMED_LED_EVENT_TABLE_DEFINES_SVH
`define TIMED_LED_EVENT_TABLE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tle_pkg.sv
// Shared types and constants for the timed LED event table.
// Used by tle_cell and timed_led_event_table; depends on nothing.
`default_nettype none

package tle_pkg;

  localparam int SLOTS = 8;
  localparam int LEDS = 8;

  localparam int SLOT_W = $clog2(SLOTS);
  // Width wide enough for both the 3-bit slot field and a cell index
  localparam int SLOT_CW = (SLOT_W > 3) ? SLOT_W : 3;
  // Width wide enough for both the 3-bit LED field and an LED index
  localparam int LED_CW = ($clog2(LEDS) > 3) ? $clog2(LEDS) : 3;
  // LEDs that appear in the packed code word
  localparam int LEDS_SHOWN = (LEDS < 8) ? LEDS : 8;

  localparam logic [2:0] CODE_OFF = 3'd0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Item travelling down the row of cells
  typedef struct packed {
    logic        active;
    op_t         op;
    logic [31:0] now;
    logic        turn_on;
    logic [1:0]  color;
    logic [2:0]  led;
    logic [31:0] due;
    logic [2:0]  slot;
    logic        placed;
    logic [2:0]  used;
  } token_t;

  // LED write requested by a cell
  typedef struct packed {
    logic       hit;
    logic [2:0] code;
    logic [2:0] led;
  } led_event_t;

endpackage

`default_nettype wire

### rtl/timed_led_event_table.sv
// Top level of the timed LED event table: a row of slot cells and the LED
// code register. Depends on tle_pkg, tle_cell and the defines header.
//
// Every item (tick, add, remove) walks the row of SLOTS slot cells, one cell
// per clock, so slots are handled in order and a later slot wins on the same
// LED. busy stays high from acceptance until the result cycle; the result is
// shown for one cycle with done high as the item leaves the last cell, and the
// next item is taken only once busy has fallen, so only one item is in the row
// at a time. The receiver cannot stall, so results must be captured in the done
// cycle. led_codes always reflects the current LED state; status and used_slot
// are meaningful only while done is high.
`default_nettype none
`include "timed_led_event_table_defines.svh"

module timed_led_event_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] now_seconds,
  input  wire logic        turn_on,
  input  wire logic [1:0]  color_choice,
  input  wire logic [2:0]  led_number,
  input  wire logic [31:0] due_time,
  input  wire logic [2:0]  slot_number,
  output logic             done,
  output logic [23:0]      led_codes,
  output logic             status,
  output logic [2:0]       used_slot
);

  tle_pkg::token_t     tok_head;
  tle_pkg::token_t     link_in [tle_pkg::SLOTS];
  tle_pkg::token_t     tok [tle_pkg::SLOTS];
  tle_pkg::led_event_t ev [tle_pkg::SLOTS];
  tle_pkg::led_event_t ev_any;
  logic [tle_pkg::SLOTS-1:0] active_vec;
  logic [2:0] led_state [tle_pkg::LEDS];
  tle_pkg::op_t op_in;

  assign op_in = tle_pkg::op_t'(operation);

  // Build the entering item
  always_comb begin
    tok_head.active  = start && !busy;
    tok_head.op      = op_in;
    tok_head.now     = now_seconds;
    tok_head.turn_on = turn_on;
    tok_head.color   = color_choice;
    tok_head.led     = led_number;
    tok_head.due     = due_time;
    tok_head.slot    = slot_number;
    tok_head.placed  = 1'b0;
    tok_head.used    = (op_in == tle_pkg::OP_REMOVE) ? slot_number : 3'd0;
  end

  // Row of slot cells; tok[i] is the item leaving cell i
  for (genvar i = 0; i < tle_pkg::SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link_in[i] = tok_head;
    end else begin : g_link
      assign link_in[i] = tok[i-1];
    end
    tle_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .index   (tle_pkg::SLOT_W'(i)),
      .tok_in  (link_in[i]),
      .tok_out (tok[i]),
      .ev      (ev[i])
    );
    assign active_vec[i] = tok[i].active;
  end

  assign busy = |active_vec;

  // Merge cell requests; only the cell holding the item raises one
  always_comb begin
    ev_any = '0;
    for (int i = 0; i < tle_pkg::SLOTS; i++) begin
      ev_any = ev_any | ev[i];
    end
  end

  // Update LED codes; an LED beyond the strip matches no entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < tle_pkg::LEDS; i++) begin
      if (rst) begin
        led_state[i] <= tle_pkg::CODE_OFF;
      end else if (ev_any.hit &&
                   (tle_pkg::LED_CW'(ev_any.led) == tle_pkg::LED_CW'(i))) begin
        led_state[i] <= ev_any.code;
      end
    end
  end

  // Pack LED codes, three bits per LED
  always_comb begin
    led_codes = '0;
    for (int i = 0; i < tle_pkg::LEDS_SHOWN; i++) begin
      led_codes[3*i +: 3] = led_state[i];
    end
  end

  // Result leaves the last cell
  assign done      = tok[tle_pkg::SLOTS-1].active;
  assign status    = (tok[tle_pkg::SLOTS-1].op == tle_pkg::OP_ADD) &&
                     !tok[tle_pkg::SLOTS-1].placed;
  assign used_slot = tok[tle_pkg::SLOTS-1].used;

  `TLE_ASSERT_NOW(a_single_item, 1'b1, $onehot0(active_vec), "more than one item in the row")
  `TLE_ASSERT_NEXT(a_item_enters, start && !busy, active_vec[0], "accepted item missing at cell 0")
  `TLE_ASSERT_NOW(a_full_slot_zero, done && status, used_slot == 3'd0, "failed add reports a slot")
  `TLE_ASSERT_NOW(a_one_led_write, ev_any.hit, busy || (start && !busy), "LED write with no item")

endmodule

`default_nettype wire

### rtl/tle_cell.sv
// One slot of the event table: holds one timed event and handles the item
// passing through it. Depends on tle_pkg.
`default_nettype none

module tle_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [tle_pkg::SLOT_W-1:0]  index,
  input  wire tle_pkg::token_t             tok_in,
  output tle_pkg::token_t                  tok_out,
  output tle_pkg::led_event_t              ev
);

  logic        valid, valid_next;
  logic        turn_on, turn_on_next;
  logic [1:0]  color, color_next;
  logic [2:0]  led, led_next;
  logic [31:0] due, due_next;
  tle_pkg::token_t tok_next;

  // Act on the item held at this cell
  always_comb begin
    valid_next   = valid;
    turn_on_next = turn_on;
    color_next   = color;
    led_next     = led;
    due_next     = due;
    tok_next     = tok_in;
    ev           = '0;
    if (tok_in.active) begin
      unique case (tok_in.op)
        tle_pkg::OP_TICK: begin
          if (valid && (tok_in.now >= due)) begin
            ev.hit     = 1'b1;
            ev.led     = led;
            ev.code    = turn_on ? ({1'b0, color} + 3'd1) : tle_pkg::CODE_OFF;
            valid_next = 1'b0;
          end
        end
        tle_pkg::OP_ADD: begin
          if (!tok_in.placed && !valid) begin
            valid_next      = 1'b1;
            turn_on_next    = tok_in.turn_on;
            color_next      = tok_in.color;
            led_next        = tok_in.led;
            due_next        = tok_in.due;
            tok_next.placed = 1'b1;
            tok_next.used   = 3'(index);
          end
        end
        tle_pkg::OP_REMOVE: begin
          if (tle_pkg::SLOT_CW'(tok_in.slot) == tle_pkg::SLOT_CW'(index)) begin
            // A free slot still turns off the LED it last held
            valid_next = 1'b0;
            ev.hit     = 1'b1;
            ev.led     = led;
            ev.code    = tle_pkg::CODE_OFF;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      turn_on <= 1'b0;
      color   <= 2'd0;
      led     <= 3'd0;
    end else begin
      valid   <= valid_next;
      turn_on <= turn_on_next;
      color   <= color_next;
      led     <= led_next;
    end
  end

  always_ff @(posedge clk) begin
    due <= due_next;
  end

  // Advance the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the timed LED event table (timed_led_event_table).
// Holds a queue-fed driver, a result monitor and a table predictor; depends on tle_pkg.
`timescale 1ns / 100ps

module tb;
  import tle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 400;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic        on;
    logic [1:0]  colour;
    logic [2:0]  led;
    logic [31:0] due;
    logic [2:0]  slot;
    int          idle_pct;
    bit          hold;
  } table_item_t;

  typedef struct {
    logic [23:0] leds;
    logic        full;
    logic [2:0]  slot;
  } table_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = OP_TICK;
  logic [31:0] now_seconds = '0;
  logic        turn_on = 1'b0;
  logic [1:0]  color_choice = '0;
  logic [2:0]  led_number = '0;
  logic [31:0] due_time = '0;
  logic [2:0]  slot_number = '0;
  logic        busy;
  logic        done;
  logic [23:0] led_codes;
  logic        status;
  logic [2:0]  used_slot;

  timed_led_event_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .now_seconds  (now_seconds),
    .turn_on      (turn_on),
    .color_choice (color_choice),
    .led_number   (led_number),
    .due_time     (due_time),
    .slot_number  (slot_number),
    .done         (done),
    .led_codes    (led_codes),
    .status       (status),
    .used_slot    (used_slot)
  );

  // Predicted table contents
  logic        ev_live [SLOTS];
  logic        ev_on [SLOTS];
  logic [1:0]  ev_colour [SLOTS];
  logic [2:0]  ev_led [SLOTS];
  logic [31:0] ev_due [SLOTS];
  logic [2:0]  led_now [LEDS];

  table_item_t   item_q[$];
  table_report_t report_q[$];
  table_item_t   held_item;
  int            mismatches = 0;
  int            results_seen = 0;
  int            cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      ev_live[i] = 1'b0;
      ev_on[i] = 1'b0;
      ev_colour[i] = '0;
      ev_led[i] = '0;
      ev_due[i] = '0;
    end
    for (int i = 0; i < LEDS; i++) led_now[i] = CODE_OFF;
  end

  // Apply one item to the predicted table and return the report it gives
  function automatic table_report_t table_step(table_item_t it);
    table_report_t r;
    bit placed;
    r.full = 1'b0;
    r.slot = '0;
    r.leds = '0;
    placed = 1'b0;
    case (it.op)
      OP_TICK: begin
        // fire due events in slot order, later slots overwrite
        for (int i = 0; i < SLOTS; i++) begin
          if (ev_live[i] && it.now >= ev_due[i]) begin
            if (ev_led[i] < LEDS)
              led_now[ev_led[i]] = ev_on[i] ? ({1'b0, ev_colour[i]} + 3'd1) : CODE_OFF;
            ev_live[i] = 1'b0;
          end
        end
      end
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !ev_live[i]) begin
            ev_live[i] = 1'b1;
            ev_on[i] = it.on;
            ev_colour[i] = it.colour;
            ev_led[i] = it.led;
            ev_due[i] = it.due;
            r.slot = 3'(i);
            placed = 1'b1;
          end
        end
        if (!placed) r.full = 1'b1;
      end
      OP_REMOVE: begin
        r.slot = it.slot;
        if (it.slot < SLOTS) begin
          ev_live[it.slot] = 1'b0;
          if (ev_led[it.slot] < LEDS) led_now[ev_led[it.slot]] = CODE_OFF;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < LEDS_SHOWN; i++) r.leds[3*i +: 3] = led_now[i];
    return r;
  endfunction

  function automatic void queue_item(op_t op, logic [31:0] now, logic on, logic [1:0] colour,
                                     logic [2:0] led, logic [31:0] due, logic [2:0] slot,
                                     int idle_pct, bit hold);
    table_item_t it;
    it.op = op;
    it.now = now;
    it.on = on;
    it.colour = colour;
    it.led = led;
    it.due = due;
    it.slot = slot;
    it.idle_pct = idle_pct;
    it.hold = hold;
    item_q.push_back(it);
  endfunction

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Driver: predict each accepted item, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) report_q.push_back(table_step(held_item));
      if (!start || !busy) begin
        if (item_q.size() > 0 && !(item_q[0].hold && report_q.size() > 0) &&
            $urandom_range(0, 99) >= item_q[0].idle_pct) begin
          held_item = item_q.pop_front();
          operation <= held_item.op;
          now_seconds <= held_item.now;
          turn_on <= held_item.on;
          color_choice <= held_item.colour;
          led_number <= held_item.led;
          due_time <= held_item.due;
          slot_number <= held_item.slot;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (report_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result %0d: leds %06h status %0d slot %0d",
                   results_seen, led_codes, status, used_slot);
      end else begin
        if (led_codes !== report_q[0].leds || status !== report_q[0].full ||
            used_slot !== report_q[0].slot) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch on result %0d: expected leds %06h status %0d slot %0d, got leds %06h status %0d slot %0d",
                     results_seen, report_q[0].leds, report_q[0].full, report_q[0].slot,
                     led_codes, status, used_slot);
        end
        void'(report_q.pop_front());
      end
    end
  end

  // Stimulus and end of run
  initial begin
    table_item_t it;
    int          pick;
    logic [31:0] clock_s;
    int          idle_tab [4];
    // the third phase has no idle gaps and starts its clock near the top of the range
    idle_tab = '{0, 62, 0, 8};

    // empty table, remove of a free slot after reset, unknown operation
    queue_item(OP_TICK, 32'd0, 1'b0, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 2'd3, 3'd7, 32'hFFFF_FFFF, 3'd0, 0, 1'b0);
    queue_item(OP_NONE, 32'hFFFF_FFFF, 1'b1, 2'd3, 3'd7, 32'hFFFF_FFFF, 3'd7, 0, 1'b0);
    // fill every slot: same LED twice, an off event after an on event, extreme due times
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd1, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd2, 3'd7, 32'd5, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b0, 2'd3, 3'd7, 32'd6, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd3, 3'd3, 32'hFFFF_FFFF, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd2, 3'd4, 32'd100, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd1, 3'd5, 32'h8000_0000, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd3, 3'd6, 32'd7, 3'd0, 0, 1'b0);
    // full table
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd3, 3'd7, 32'd0, 3'd5, 0, 1'b0);
    // fire in stages
    queue_item(OP_TICK, 32'd5, 1'b0, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_TICK, 32'd6, 1'b0, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_ADD, 32'd0, 1'b1, 2'd0, 3'd2, 32'd0, 3'd0, 0, 1'b0);
    // remove a live slot, then the same slot again
    queue_item(OP_REMOVE, 32'd0, 1'b0, 2'd0, 3'd0, 32'd0, 3'd4, 0, 1'b0);
    queue_item(OP_REMOVE, 32'd0, 1'b0, 2'd0, 3'd0, 32'd0, 3'd4, 0, 1'b0);
    queue_item(OP_TICK, 32'h7FFF_FFFF, 1'b0, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_TICK, 32'hFFFF_FFFF, 1'b0, 2'd0, 3'd0, 32'd0, 3'd0, 0, 1'b0);
    queue_item(OP_REMOVE, 32'd0, 1'b0, 2'd0, 3'd0, 32'd0, 3'd7, 0, 1'b0);

    // random phases; each starts only once the block has drained
    for (int phase = 0; phase < 4; phase++) begin
      clock_s = (phase == 2) ? 32'hFFFF_FFF0 : $urandom;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        it.now = $urandom;
        it.on = 1'($urandom);
        it.colour = 2'($urandom_range(0, 3));
        it.led = 3'($urandom_range(0, 7));
        it.due = $urandom;
        it.slot = 3'($urandom_range(0, 7));
        it.idle_pct = idle_tab[phase];
        it.hold = (n == 0);
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          it.op = OP_ADD;
          // mostly due shortly after the running clock
          if ($urandom_range(0, 9) != 0) it.due = clock_s + 32'($urandom_range(0, 12));
        end else if (pick < 72) begin
          it.op = OP_TICK;
          if ($urandom_range(0, 9) != 0) begin
            clock_s = clock_s + 32'($urandom_range(0, 4));
            it.now = clock_s;
          end
        end else if (pick < 95) begin
          it.op = OP_REMOVE;
        end else begin
          it.op = OP_NONE;
        end
        item_q.push_back(it);
      end
    end

    // wait for every item to be taken and answered, then let the row settle
    do @(negedge clk);
    while (item_q.size() > 0 || start || report_q.size() > 0);
    repeat (2 * SLOTS + 4) @(negedge clk);

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Reset
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
